>>> rtl/rmh_pkg.sv
// rmh_pkg: widths, limits, register codes and shared types of the row mode histogram.
// No dependencies; every other file of the block but rmh_ram imports this package.
`timescale 1ns / 1ps

package rmh_pkg;

	localparam int SAMPLE_W    = 8;
	localparam int BIN_COUNT   = 256;
	localparam int CNT_W       = 11;
	localparam int POS_W       = 10;
	localparam int ROW_W       = 8;
	localparam int LEN_W       = 11;
	localparam int ROWS_W      = 9;
	localparam int MAX_ROW_LEN = 1024;
	localparam int MAX_ROWS    = 256;
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;

	localparam logic [LEN_W-1:0]  ROW_LENGTH_RST = LEN_W'(256);
	localparam logic [ROWS_W-1:0] ROW_COUNT_RST  = ROWS_W'(16);

	typedef enum logic {
		REG_ROW_LENGTH = 1'b0,
		REG_ROW_COUNT  = 1'b1
	} rmh_reg_t;

	typedef struct packed {
		logic [LEN_W-1:0]  row_length;
		logic [ROWS_W-1:0] row_count;
	} rmh_cfg_t;

	typedef struct packed {
		logic                push;
		logic [SAMPLE_W-1:0] mode_value;
		logic [ROW_W-1:0]    row_index;
		logic                last_row;
	} rmh_row_t;

endpackage

>>> rtl/rmh_sample_if.sv
// rmh_sample_if: valid/ready channel that carries one pixel sample per item.
// Depends on rmh_pkg for the sample width.
`timescale 1ns / 1ps

interface rmh_sample_if import rmh_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

>>> rtl/rmh_result_if.sv
// rmh_result_if: valid/ready channel that carries one row result per item.
// Depends on rmh_pkg for the field widths.
`timescale 1ns / 1ps

interface rmh_result_if import rmh_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] mode_value;
	logic [ROW_W-1:0]    row_index;
	logic                last_row;

	modport source (output valid, output mode_value, output row_index, output last_row,
		input ready);
	modport sink (input valid, input mode_value, input row_index, input last_row,
		output ready);
endinterface

>>> rtl/rmh_ram.sv
// rmh_ram: generic single-write, single-read RAM with registered read data.
// Standalone; read returns the contents before a same-cycle write.
`timescale 1ns / 1ps

module rmh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/rmh_regs.sv
// rmh_regs: APB register file for row length and row count, with limit clamping.
// Depends on rmh_pkg.
`timescale 1ns / 1ps

module rmh_regs import rmh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output rmh_cfg_t          cfg
);

	logic [LEN_W-1:0]  row_length_q;
	logic [ROWS_W-1:0] row_count_q;
	logic              wr;
	rmh_reg_t          idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;
	assign idx    = rmh_reg_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_LENGTH_RST;
			row_count_q  <= ROW_COUNT_RST;
		end else if (wr) begin
			case (idx)
				REG_ROW_LENGTH: row_length_q <= pwdata[LEN_W-1:0];
				REG_ROW_COUNT:  row_count_q  <= pwdata[ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ROW_LENGTH: prdata = APB_DW'(row_length_q);
			REG_ROW_COUNT:  prdata = APB_DW'(row_count_q);
			default:        prdata = '0;
		endcase
	end

	// zero acts as one, oversize saturates
	always_comb begin
		if (row_length_q == '0) begin
			cfg.row_length = LEN_W'(1);
		end else if (row_length_q > LEN_W'(MAX_ROW_LEN)) begin
			cfg.row_length = LEN_W'(MAX_ROW_LEN);
		end else begin
			cfg.row_length = row_length_q;
		end
		if (row_count_q == '0) begin
			cfg.row_count = ROWS_W'(1);
		end else if (row_count_q > ROWS_W'(MAX_ROWS)) begin
			cfg.row_count = ROWS_W'(MAX_ROWS);
		end else begin
			cfg.row_count = row_count_q;
		end
	end

endmodule

>>> rtl/rmh_hist.sv
// rmh_hist: per-row histogram in RAM with valid bits, write forwarding and mode tracking.
// Depends on rmh_pkg, rmh_sample_if and rmh_ram.
`timescale 1ns / 1ps

module rmh_hist import rmh_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	rmh_sample_if.sink    smp,
	input  rmh_cfg_t      cfg,
	input  logic          hold,
	output rmh_row_t      row
);

	logic                 vld_s1;
	logic [SAMPLE_W-1:0]  sample_s1;
	logic [CNT_W-1:0]     ram_rd;
	logic [BIN_COUNT-1:0] bin_vld_q;
	logic                 fwd_vld_q;
	logic [SAMPLE_W-1:0]  fwd_addr_q;
	logic [CNT_W-1:0]     fwd_cnt_q;
	logic [CNT_W-1:0]     best_cnt_q;
	logic [SAMPLE_W-1:0]  best_val_q;
	logic [POS_W-1:0]     pix_q;
	logic [ROW_W-1:0]     row_q;

	logic                 accept;
	logic                 adv;
	logic [CNT_W-1:0]     cnt_old;
	logic [CNT_W-1:0]     cnt_new;
	logic                 take;
	logic [CNT_W-1:0]     best_cnt_nx;
	logic [SAMPLE_W-1:0]  best_val_nx;
	logic                 row_end;
	logic                 last;

	assign accept = smp.valid & smp.ready;

	rmh_ram #(
		.WIDTH (CNT_W),
		.DEPTH (BIN_COUNT)
	) u_bins (
		.clk     (clk),
		.wr_en   (adv),
		.wr_addr (sample_s1),
		.wr_data (cnt_new),
		.rd_en   (accept),
		.rd_addr (smp.sample),
		.rd_data (ram_rd)
	);

	always_comb begin
		if (fwd_vld_q && fwd_addr_q == sample_s1) begin
			cnt_old = fwd_cnt_q;
		end else if (bin_vld_q[sample_s1]) begin
			cnt_old = ram_rd;
		end else begin
			cnt_old = '0;
		end
		cnt_new     = cnt_old + CNT_W'(1);
		take        = (cnt_new > best_cnt_q) ||
			(cnt_new == best_cnt_q && sample_s1 < best_val_q);
		best_cnt_nx = take ? cnt_new : best_cnt_q;
		best_val_nx = take ? sample_s1 : best_val_q;
		row_end     = ({1'b0, pix_q} + LEN_W'(1)) >= cfg.row_length;
		last        = ({1'b0, row_q} + ROWS_W'(1)) >= cfg.row_count;
		adv         = vld_s1 && !(row_end && hold);
		smp.ready   = !vld_s1 || adv;
	end

	assign row.push       = adv && row_end;
	assign row.mode_value = best_val_nx;
	assign row.row_index  = row_q;
	assign row.last_row   = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= smp.sample;
		end
		if (adv) begin
			fwd_addr_q <= sample_s1;
			fwd_cnt_q  <= cnt_new;
		end
	end

	// on the row's last pixel clear the whole row at once, else mark the bin and track the mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q  <= '0;
			fwd_vld_q  <= 1'b0;
			best_cnt_q <= '0;
			best_val_q <= '0;
			pix_q      <= '0;
			row_q      <= '0;
		end else if (adv) begin
			if (row_end) begin
				bin_vld_q  <= '0;
				fwd_vld_q  <= 1'b0;
				best_cnt_q <= '0;
				best_val_q <= '0;
				pix_q      <= '0;
				row_q      <= last ? '0 : row_q + ROW_W'(1);
			end else begin
				bin_vld_q[sample_s1] <= 1'b1;
				fwd_vld_q            <= 1'b1;
				best_cnt_q           <= best_cnt_nx;
				best_val_q           <= best_val_nx;
				pix_q                <= pix_q + POS_W'(1);
			end
		end
	end

endmodule

>>> rtl/row_mode_histogram.sv
// row_mode_histogram: top level; per-row mode of an 8-bit pixel stream.
// Depends on rmh_pkg, rmh_sample_if, rmh_result_if, rmh_regs and rmh_hist.
//
//   channel   direction  fields                                  handshake
//   samples   in         sample[7:0]                             valid/ready
//   results   out        mode_value[7:0] row_index[7:0] last_row valid/ready
//   apb       in/out     row_length @0x0, row_count @0x4         psel/penable
//
// One sample per cycle sustained unless a held result stalls the pipeline; a row's
// result is registered after its last sample is taken (histogram RAM read on the
// taking edge, then update into the result register).
// Reset clears the bin valid bits, mode tracker and positions at once; no sweep.
// A held result stalls the pipeline only when the next row end reaches it.
`timescale 1ns / 1ps

module row_mode_histogram import rmh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	rmh_sample_if.sink        samples,
	rmh_result_if.source      results
);

	rmh_cfg_t            cfg;
	rmh_row_t            row;
	logic                hold;
	logic                res_vld_q;
	logic [SAMPLE_W-1:0] mode_q;
	logic [ROW_W-1:0]    index_q;
	logic                last_q;

	rmh_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rmh_hist u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (samples),
		.cfg    (cfg),
		.hold   (hold),
		.row    (row)
	);

	assign hold = res_vld_q && !results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (row.push) begin
			res_vld_q <= 1'b1;
		end else if (results.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (row.push) begin
			mode_q  <= row.mode_value;
			index_q <= row.row_index;
			last_q  <= row.last_row;
		end
	end

	assign results.valid      = res_vld_q;
	assign results.mode_value = mode_q;
	assign results.row_index  = index_q;
	assign results.last_row   = last_q;

endmodule

>>> verif/row_mode_histogram_test.sv
// row_mode_histogram_test: self-checking bench for the per-row mode histogram.
// Drives pixel items and APB register writes, predicts every row result and
// checks each one in order. Depends on rmh_pkg, rmh_sample_if, rmh_result_if, row_mode_histogram.
`timescale 1ns / 1ps

module row_mode_histogram_test;
	import rmh_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int ITEM_TARGET   = 1790;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [SAMPLE_W-1:0] mode_value;
		logic [ROW_W-1:0]    row_index;
		logic                last_row;
	} row_mode_t;

	logic              clk;
	logic              arst_n;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [APB_AW-1:0] paddr   = '0;
	logic [APB_DW-1:0] pwdata  = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	rmh_sample_if samples_if ();
	rmh_result_if results_if ();

	row_mode_histogram dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.samples (samples_if),
		.results (results_if)
	);

	// histogram model state
	logic [LEN_W-1:0]    cfg_len;
	logic [ROWS_W-1:0]   cfg_rows;
	logic [CNT_W-1:0]    bin_cnt [BIN_COUNT];
	logic [CNT_W-1:0]    lead_cnt;
	logic [SAMPLE_W-1:0] lead_val;
	logic [POS_W-1:0]    col_pos;
	logic [ROW_W-1:0]    row_pos;

	row_mode_t           pending_modes [$];
	logic [SAMPLE_W-1:0] pixel_q [$];

	int pushed_cnt      = 0;
	int taken_cnt       = 0;
	int fail_cnt        = 0;
	int quiet_cycles    = 0;
	int sender_idle_pct = 0;
	int stall_pct       = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int clamp_to(input int v, input int hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic note_mismatch(input string what, input int want, input int got);
		fail_cnt++;
		$display("%0t %s expected %0d actual %0d", $time, what, want, got);
	endtask

	task automatic clear_row();
		foreach (bin_cnt[i])
			bin_cnt[i] = '0;
		lead_cnt = '0;
		lead_val = '0;
		col_pos  = '0;
	endtask

	task automatic histogram_step(input logic [SAMPLE_W-1:0] px);
		int               len;
		int               rows;
		logic [CNT_W-1:0] c;
		row_mode_t        r;
		len  = clamp_to(int'(cfg_len), MAX_ROW_LEN);
		rows = clamp_to(int'(cfg_rows), MAX_ROWS);
		c = bin_cnt[px] + 1'b1;
		bin_cnt[px] = c;
		if (c > lead_cnt || (c == lead_cnt && px < lead_val)) begin
			lead_cnt = c;
			lead_val = px;
		end
		if (int'(col_pos) + 1 < len) begin
			col_pos = col_pos + 1'b1;
		end else begin
			r.mode_value = lead_val;
			r.row_index  = row_pos;
			r.last_row   = (int'(row_pos) + 1 >= rows);
			pending_modes.push_back(r);
			clear_row();
			row_pos = r.last_row ? '0 : row_pos + 1'b1;
		end
	endtask

	task automatic cfg_check(input rmh_reg_t idx);
		int want;
		want = (idx == REG_ROW_LENGTH) ? int'(cfg_len) : int'(cfg_rows);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= APB_AW'(int'(idx) * 4);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== APB_DW'(want))
			note_mismatch(idx == REG_ROW_LENGTH ? "row_length readback" : "row_count readback",
				want, int'(prdata));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic cfg_write(input rmh_reg_t idx, input int unsigned value);
		logic [APB_DW-1:0] mask;
		logic [APB_DW-1:0] data;
		mask = (idx == REG_ROW_LENGTH) ? APB_DW'((1 << LEN_W) - 1) : APB_DW'((1 << ROWS_W) - 1);
		data = ($urandom() & ~mask) | (APB_DW'(value) & mask);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(int'(idx) * 4);
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_ROW_LENGTH)
			cfg_len = data[LEN_W-1:0];
		else
			cfg_rows = data[ROWS_W-1:0];
		cfg_check(idx);
	endtask

	task automatic feed(input logic [SAMPLE_W-1:0] px);
		pixel_q.push_back(px);
		pushed_cnt++;
	endtask

	// hold until every item is taken and every row result is back
	task automatic drain();
		while (taken_cnt != pushed_cnt || pending_modes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// pixel driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_if.valid  <= 1'b0;
			samples_if.sample <= '0;
		end else if (!samples_if.valid || samples_if.ready) begin
			if (pixel_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				samples_if.valid  <= 1'b1;
				samples_if.sample <= pixel_q.pop_front();
			end else begin
				samples_if.valid <= 1'b0;
			end
		end
	end

	// result backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			results_if.ready <= 1'b0;
		else
			results_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin : monitor
		row_mode_t want;
		logic      moved;
		if (arst_n) begin
			moved = 1'b0;
			if (results_if.valid && results_if.ready) begin
				moved = 1'b1;
				if (pending_modes.size() == 0) begin
					fail_cnt++;
					$display("%0t unexpected result expected none actual %0d/%0d/%0d",
						$time, results_if.mode_value, results_if.row_index,
						results_if.last_row);
				end else begin
					want = pending_modes.pop_front();
					if (results_if.mode_value !== want.mode_value)
						note_mismatch("mode_value", want.mode_value, results_if.mode_value);
					if (results_if.row_index !== want.row_index)
						note_mismatch("row_index", want.row_index, results_if.row_index);
					if (results_if.last_row !== want.last_row)
						note_mismatch("last_row", want.last_row, results_if.last_row);
				end
			end
			if (samples_if.valid && samples_if.ready) begin
				moved = 1'b1;
				histogram_step(samples_if.sample);
				taken_cnt++;
			end
			if (moved) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("FAILURE");
					$finish;
				end
			end
		end
	end

	initial begin : stimulus
		int                  phase;
		int                  n;
		int                  style;
		int                  k;
		int                  len;
		int                  rows;
		int                  pick;
		logic [SAMPLE_W-1:0] palette [4];
		logic [SAMPLE_W-1:0] px;

		arst_n <= 1'b0;
		cfg_len  = ROW_LENGTH_RST;
		cfg_rows = ROW_COUNT_RST;
		row_pos  = '0;
		clear_row();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		cfg_check(REG_ROW_LENGTH);
		cfg_check(REG_ROW_COUNT);

		// ties both ways, then frame wrap
		cfg_write(REG_ROW_LENGTH, 4);
		cfg_write(REG_ROW_COUNT, 2);
		feed(8'd0);   feed(8'd255); feed(8'd255); feed(8'd0);
		feed(8'd255); feed(8'd255); feed(8'd255); feed(8'd0);
		feed(8'd200); feed(8'd200); feed(8'd100); feed(8'd100);
		drain();

		// zero length and count act as one
		cfg_write(REG_ROW_LENGTH, 0);
		cfg_write(REG_ROW_COUNT, 0);
		feed(8'h55);
		feed(8'hAA);
		drain();

		// shrink length mid-row, then count mid-frame
		cfg_write(REG_ROW_LENGTH, 6);
		cfg_write(REG_ROW_COUNT, 3);
		feed(8'd9); feed(8'd9); feed(8'd9);
		drain();
		cfg_write(REG_ROW_LENGTH, 2);
		feed(8'd7);
		drain();
		cfg_write(REG_ROW_COUNT, 1);
		feed(8'd3);
		feed(8'd4);
		drain();

		phase = 0;
		while (pushed_cnt < ITEM_TARGET) begin
			case (phase % 4)
				0: begin sender_idle_pct = 0;  stall_pct = 0;  end
				1: begin sender_idle_pct = 88; stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  stall_pct = 88; end
				default: begin sender_idle_pct = 34; stall_pct = 34; end
			endcase

			style = $urandom_range(9);
			style = (style < 6) ? 0 : (style < 9) ? 1 : 2;
			n = $urandom_range(20, 120);
			pick = $urandom_range(19);
			len  = (pick == 0) ? 0 : (pick < 5) ? $urandom_range(1, 3) : $urandom_range(4, 40);
			pick = $urandom_range(19);
			rows = (pick == 0) ? 0 : (pick == 1) ? 256 : (pick == 2) ? $urandom_range(257, 511) :
				$urandom_range(1, 8);

			if (phase == 2) begin
				len   = $urandom_range(1) ? 1024 : 2047;
				rows  = $urandom_range(1, 4);
				n     = 1024 + $urandom_range(5);
				style = 3;
			end else if (phase == 5) begin
				len = 1;
				rows = $urandom_range(1) ? 256 : 511;
				n = 260;
			end else if (phase == 7) begin
				len = 1024;
				rows = 1;
				n = $urandom_range(20, 40);
			end

			cfg_write(REG_ROW_LENGTH, len);
			cfg_write(REG_ROW_COUNT, rows);

			k = $urandom_range(1, 4);
			foreach (palette[i])
				palette[i] = SAMPLE_W'($urandom_range(255));
			repeat (n) begin
				case (style)
					0: px = palette[$urandom_range(k - 1)];
					1: px = SAMPLE_W'($urandom_range(255));
					2: px = ($urandom_range(3) == 0) ? SAMPLE_W'($urandom_range(255)) :
						($urandom_range(1) ? 8'hFF : 8'h00);
					default: px = ($urandom_range(9) < 7) ? palette[0] :
						SAMPLE_W'($urandom_range(255));
				endcase
				feed(px);
			end
			drain();
			phase++;
		end

		drain();
		if (fail_cnt == 0 && pending_modes.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
